/* rtl/core/derarc_pkg.sv */
// shared types, codes and helpers for the der object identifier arc decoder
`default_nettype none

package derarc_pkg;

    // reset value of the content length limit
    localparam logic [31:0] C_MAX_CONTENT_RST = 32'h0000_ffff;
    // first content byte splits into byte / 40 and byte % 40
    localparam int unsigned C_FIRST_DIV = 40;
    // reciprocal of 40 scaled by 2^13, exact for all 8-bit values
    localparam logic [7:0]  C_DIV40_MUL   = 8'd205;
    localparam int unsigned C_DIV40_SHIFT = 13;
    // continuation / long-form flag and 7-bit group mask
    localparam int unsigned C_CONT_BIT = 7;
    localparam logic [6:0]  C_GROUP_MASK = 7'h7f;
    // largest number of long-form length bytes
    localparam logic [6:0]  C_MAX_LEN_BYTES = 7'd4;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEN     = 3'd1,
        PH_LENLONG = 3'd2,
        PH_FIRST   = 3'd3,
        PH_ARCS    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_ARC       = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_LEN_WIDE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] arc_value;
        t_status     status;
        logic        last;
        logic [31:0] element_length;
    } t_result;

    // quotient of an 8-bit value by 40
    function automatic logic [2:0] f_div40(input logic [7:0] b);
        logic [15:0] prod;
        prod = 16'(b) * 16'(C_DIV40_MUL);
        return prod[15:C_DIV40_SHIFT];
    endfunction

    // remainder of an 8-bit value by 40
    function automatic logic [5:0] f_mod40(input logic [7:0] b);
        logic [7:0] prod;
        prod = 8'(f_div40(b)) * 8'(C_FIRST_DIV);
        return 6'(b - prod);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/der_oid_arc_decoder_top.sv */
// der object identifier decoder: byte stream in, one arc per result item out
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one byte of an encoded
//   object identifier element per item; i_start_req marks the tag byte and
//   restarts decoding whatever was in progress. Output channel
//   (o_out_valid / i_out_ready) delivers arcs, or one error/empty item,
//   with o_last on the final item of an element and o_element_length then
//   giving header plus content bytes consumed.
//   Config channel (i_cfg_valid / o_cfg_ready) writes max_content; it is
//   always ready and is meant to be written while the block is idle.
// Timing:
//   A byte is held in the input register, is decoded there and its
//   results enter a three-slot result queue, whose head drives the
//   outputs. One byte per cycle is sustained; the extra result of the
//   first content byte is absorbed by the queue, so the input stalls
//   only when the receiver holds off.
// Reset and stalls:
//   Synchronous active-low reset empties the queue, drops the held byte,
//   returns to idle awaiting a tag and sets max_content to 65535. When the
//   receiver stalls, the queue fills and o_in_ready falls; nothing is lost.
`default_nettype none

module der_oid_arc_decoder_top (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [31:0]           i_cfg_max_content,
    // byte input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_start_req,
    // result output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [31:0]                o_arc_value,
    output logic [1:0]                 o_status,
    output logic                       o_last,
    output logic [31:0]                o_element_length
);
    import derarc_pkg::*;

    localparam int unsigned QDEPTH = 3;

    // configuration
    logic [31:0] r_max_content;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    // decode state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_lbl, n_lbl;
    logic [31:0] r_cl, n_cl;
    logic [31:0] r_seen, n_seen;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_hc, n_hc;

    // result queue, slot 0 is the head
    t_result     r_q [QDEPTH];
    t_result     n_q [QDEPTH];
    logic [1:0]  r_cnt, n_cnt;

    // decode outputs
    t_result     res0, res1;
    logic [1:0]  push_n;

    logic        pop, advance;
    logic [1:0]  cnt_p;

    // shared decode terms
    logic [7:0]  c;
    logic [6:0]  len_n;
    logic [31:0] long_cl;
    logic [2:0]  lbl_dec;
    logic [31:0] seen_inc;
    logic [31:0] acc_new;
    logic        arcs_end;
    logic        len_done;
    logic [31:0] done_cl;
    logic        done_empty;
    logic        done_big;
    logic [31:0] hc_inc_len;

    assign c        = r_in_byte;
    assign len_n    = c[6:0] & C_GROUP_MASK;
    assign long_cl  = {r_cl[23:0], c};
    assign lbl_dec  = r_lbl - 3'd1;
    assign seen_inc = r_seen + 32'd1;
    assign acc_new  = {r_acc[24:0], c[6:0] & C_GROUP_MASK};
    assign arcs_end = seen_inc >= r_cl;
    assign hc_inc_len = 32'(r_hc + 3'd1);

    // length completion: short form, indefinite long form, or last long byte
    always_comb begin
        len_done = 1'b0;
        done_cl  = 32'd0;
        if (r_phase == PH_LEN && !c[C_CONT_BIT]) begin
            len_done = 1'b1;
            done_cl  = 32'(c);
        end else if (r_phase == PH_LEN && len_n == 7'd0) begin
            len_done = 1'b1;
        end else if (r_phase == PH_LENLONG && lbl_dec == 3'd0) begin
            len_done = 1'b1;
            done_cl  = long_cl;
        end
    end
    assign done_empty = done_cl == 32'd0;
    assign done_big   = done_cl > r_max_content;

    // queue control
    assign pop     = (r_cnt != 2'd0) && i_out_ready;
    assign cnt_p   = r_cnt - 2'(pop);
    assign advance = r_in_valid && (cnt_p <= 2'd1);

    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (r_in_start) begin
            n_phase = PH_LEN;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_LEN: begin
                    if (len_done) begin
                        n_phase = (done_empty || done_big) ? PH_IDLE : PH_FIRST;
                    end else if (len_n > C_MAX_LEN_BYTES) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_LENLONG;
                    end
                end
                PH_LENLONG: begin
                    if (len_done) begin
                        n_phase = (done_empty || done_big) ? PH_IDLE : PH_FIRST;
                    end
                end
                PH_FIRST: begin
                    n_phase = (r_cl == 32'd1) ? PH_IDLE : PH_ARCS;
                end
                PH_ARCS: begin
                    if (arcs_end) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // datapath next values and results
    always_comb begin
        n_lbl  = r_lbl;
        n_cl   = r_cl;
        n_seen = r_seen;
        n_acc  = r_acc;
        n_hc   = r_hc;
        res0   = '{arc_value: 32'd0, status: ST_ARC, last: 1'b0, element_length: 32'd0};
        res1   = res0;
        push_n = 2'd0;
        if (r_in_start) begin
            n_hc   = 3'd1;
            n_lbl  = 3'd0;
            n_cl   = 32'd0;
            n_seen = 32'd0;
            n_acc  = 32'd0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    push_n = 2'd0;
                end
                PH_LEN, PH_LENLONG: begin
                    n_hc = r_hc + 3'd1;
                    if (r_phase == PH_LENLONG) begin
                        n_cl  = long_cl;
                        n_lbl = lbl_dec;
                    end else if (c[C_CONT_BIT]) begin
                        n_cl  = 32'd0;
                        n_lbl = len_n[2:0];
                    end else begin
                        n_cl  = 32'(c);
                    end
                    if (len_done && (done_empty || done_big)) begin
                        push_n              = 2'd1;
                        res0.status         = done_empty ? ST_EMPTY : ST_TOO_LONG;
                        res0.last           = 1'b1;
                        res0.element_length = hc_inc_len;
                    end else if (!len_done && r_phase == PH_LEN
                                 && len_n > C_MAX_LEN_BYTES) begin
                        push_n              = 2'd1;
                        res0.status         = ST_LEN_WIDE;
                        res0.last           = 1'b1;
                        res0.element_length = hc_inc_len;
                    end
                end
                PH_FIRST: begin
                    n_seen          = 32'd1;
                    n_acc           = 32'd0;
                    push_n          = 2'd2;
                    res0.arc_value  = 32'(f_div40(c));
                    res1.arc_value  = 32'(f_mod40(c));
                    if (r_cl == 32'd1) begin
                        res1.last           = 1'b1;
                        res1.element_length = 32'(r_hc) + 32'd1;
                    end
                end
                PH_ARCS: begin
                    n_seen = seen_inc;
                    n_acc  = acc_new;
                    if (!c[C_CONT_BIT] || arcs_end) begin
                        n_acc          = 32'd0;
                        push_n         = 2'd1;
                        res0.arc_value = acc_new;
                        if (arcs_end) begin
                            res0.last           = 1'b1;
                            res0.element_length = 32'(r_hc) + seen_inc;
                        end
                    end
                end
                default: begin
                    push_n = 2'd0;
                end
            endcase
        end
    end

    // queue next contents: shift on pop, then append new results
    always_comb begin
        for (int k = 0; k < QDEPTH; k++) begin
            if (pop && k < QDEPTH - 1) begin
                n_q[k] = r_q[k + 1];
            end else begin
                n_q[k] = r_q[k];
            end
        end
        n_cnt = cnt_p;
        if (advance) begin
            for (int k = 0; k < QDEPTH; k++) begin
                if (push_n != 2'd0 && 2'(k) == cnt_p) begin
                    n_q[k] = res0;
                end
                if (push_n == 2'd2 && 2'(k) == cnt_p + 2'd1) begin
                    n_q[k] = res1;
                end
            end
            n_cnt = cnt_p + push_n;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_content <= C_MAX_CONTENT_RST;
            r_in_valid    <= 1'b0;
            r_phase       <= PH_IDLE;
            r_lbl         <= 3'd0;
            r_cl          <= 32'd0;
            r_seen        <= 32'd0;
            r_acc         <= 32'd0;
            r_hc          <= 3'd0;
            r_cnt         <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                r_max_content <= i_cfg_max_content;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_phase <= n_phase;
                r_lbl   <= n_lbl;
                r_cl    <= n_cl;
                r_seen  <= n_seen;
                r_acc   <= n_acc;
                r_hc    <= n_hc;
            end
            r_cnt <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_start_req;
        end
        for (int k = 0; k < QDEPTH; k++) begin
            r_q[k] <= n_q[k];
        end
    end

    // output from queue head
    assign o_out_valid      = r_cnt != 2'd0;
    assign o_arc_value      = r_q[0].arc_value;
    assign o_status         = r_q[0].status;
    assign o_last           = r_q[0].last;
    assign o_element_length = r_q[0].element_length;

    // error and empty items always close the element
    a_status_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_ARC) |-> o_last)
        else $error("non-arc status without last");

    // length is reported only on the final item
    a_len_only_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> (o_element_length == 32'd0))
        else $error("element length on non-final item");

    // queue never overfills
    a_queue_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> (3'(cnt_p) + 3'(push_n)) <= 3'(QDEPTH))
        else $error("result queue overflow");

    // a tag byte always restarts length parsing
    a_tag_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_start |=> r_phase == PH_LEN)
        else $error("tag byte did not restart element");

    // only the first content byte yields two results
    a_push_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (push_n == 2'd2) |-> r_phase == PH_FIRST)
        else $error("two results outside first content byte");

endmodule

`default_nettype wire
